/* rtl/tlrc_pkg.sv */
// Shared types and constants of the two-way LRU read cache.
package tlrc_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned CNT_W  = 32;

  localparam logic REQ_PRELOAD = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  localparam logic WAY_ZERO = 1'b0;
  localparam logic WAY_ONE  = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

endpackage

/* rtl/tlrc_in_if.sv */
// Request channel of the cache: valid/ready handshake with the request payload.
interface tlrc_in_if #(
  parameter int unsigned ADDR_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [ADDR_WIDTH-1:0]         address;
  logic [tlrc_pkg::DATA_W-1:0]   write_data;

  modport source (output valid, output req_type, output address, output write_data,
                  input ready);
  modport sink   (input valid, input req_type, input address, input write_data,
                  output ready);
endinterface

/* rtl/tlrc_out_if.sv */
// Result channel of the cache: valid/ready handshake with the read result payload.
interface tlrc_out_if;
  logic                          valid;
  logic                          ready;
  logic [tlrc_pkg::DATA_W-1:0]   read_data;
  logic                          hit;
  logic                          served_way;
  logic [tlrc_pkg::CNT_W-1:0]    hit_total;
  logic [tlrc_pkg::CNT_W-1:0]    miss_total;

  modport source (output valid, output read_data, output hit, output served_way,
                  output hit_total, output miss_total, input ready);
  modport sink   (input valid, input read_data, input hit, input served_way,
                  input hit_total, input miss_total, output ready);
endinterface

/* rtl/tlrc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module tlrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/two_way_lru_read_cache.sv */
// Top level of the two-way set-associative LRU read cache.
//
// A preload beat writes one byte into the backing store and does not leave the idle state.
// A read beat has a read step and a compare step: the first reads the tag/line
// memories of both ways and the addressed line of the backing store, the second
// compares tags, selects the byte, writes the set back with its new LRU bit (and
// refilled line on a miss) and loads the result register. The result register
// lets the next request be taken while a result waits; a read only stalls in its
// compare step while the previous result is still unclaimed. After reset the block
// clears the valid and LRU bits of every set before it takes the first request.
module two_way_lru_read_cache #(
  parameter int unsigned ADDR_WIDTH = 16,
  parameter int unsigned NUM_SETS   = 64,
  parameter int unsigned LINE_BYTES = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  tlrc_in_if.sink      in_ch,
  tlrc_out_if.source   out_ch
);

  localparam int unsigned OFF_W    = $clog2(LINE_BYTES);
  localparam int unsigned SET_W    = $clog2(NUM_SETS);
  localparam int unsigned TAG_W    = ADDR_WIDTH - OFF_W - SET_W;
  localparam int unsigned DW       = tlrc_pkg::DATA_W;
  localparam int unsigned LINE_W   = LINE_BYTES * DW;
  localparam int unsigned LADDR_W  = ADDR_WIDTH - OFF_W;
  localparam int unsigned BANK_DEP = 2 ** LADDR_W;
  localparam int unsigned W0_W     = 2 + TAG_W + LINE_W;
  localparam int unsigned W1_W     = 1 + TAG_W + LINE_W;

  tlrc_pkg::state_t state_r, state_nxt;

  logic [SET_W-1:0]      clr_idx_r, clr_idx_nxt;
  logic [ADDR_WIDTH-1:0] addr_r, addr_nxt;
  logic [tlrc_pkg::CNT_W-1:0] hit_cnt_r, hit_cnt_nxt, miss_cnt_r, miss_cnt_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [DW-1:0]         out_data_r, out_data_nxt;
  logic                  out_hit_r, out_hit_nxt;
  logic                  out_way_r, out_way_nxt;

  logic in_accept, rd_issue, pre_issue, slot_free, look_done, clearing;

  logic [SET_W-1:0]   in_set, cur_set, way_waddr;
  logic [LADDR_W-1:0] in_laddr;
  logic [OFF_W-1:0]   in_off, cur_off;
  logic [TAG_W-1:0]   cur_tag;

  logic [W0_W-1:0]   w0_rdata, w0_wdata;
  logic [W1_W-1:0]   w1_rdata, w1_wdata;
  logic              w0_we, w1_we;
  logic [LINE_W-1:0] fill_line;

  logic              v0, v1, lru0, hit0, hit1, hit_any, way_sel;
  logic [TAG_W-1:0]  t0, t1;
  logic [LINE_W-1:0] l0, l1, line_sel;

  assign in_set   = in_ch.address[OFF_W +: SET_W];
  assign in_laddr = in_ch.address[ADDR_WIDTH-1 -: LADDR_W];
  assign in_off   = in_ch.address[OFF_W-1:0];
  assign cur_set  = addr_r[OFF_W +: SET_W];
  assign cur_off  = addr_r[OFF_W-1:0];
  assign cur_tag  = addr_r[ADDR_WIDTH-1 -: TAG_W];

  assign in_accept = in_ch.valid && in_ch.ready;
  assign rd_issue  = in_accept && (in_ch.req_type == tlrc_pkg::REQ_READ);
  assign pre_issue = in_accept && (in_ch.req_type == tlrc_pkg::REQ_PRELOAD);
  assign slot_free = !out_valid_r || out_ch.ready;

  // Backing store: one byte-wide bank per line offset, so all bytes of a line are read together.
  for (genvar b = 0; b < LINE_BYTES; b++) begin : g_bank
    tlrc_ram #(
      .WIDTH (DW),
      .DEPTH (BANK_DEP)
    ) u_bank (
      .clk   (clk),
      .we    (pre_issue && (in_off == OFF_W'(b))),
      .waddr (in_laddr),
      .wdata (in_ch.write_data),
      .re    (rd_issue),
      .raddr (in_laddr),
      .rdata (fill_line[b*DW +: DW])
    );
  end

  tlrc_ram #(
    .WIDTH (W0_W),
    .DEPTH (NUM_SETS)
  ) u_way0 (
    .clk   (clk),
    .we    (w0_we),
    .waddr (way_waddr),
    .wdata (w0_wdata),
    .re    (rd_issue),
    .raddr (in_set),
    .rdata (w0_rdata)
  );

  tlrc_ram #(
    .WIDTH (W1_W),
    .DEPTH (NUM_SETS)
  ) u_way1 (
    .clk   (clk),
    .we    (w1_we),
    .waddr (way_waddr),
    .wdata (w1_wdata),
    .re    (rd_issue),
    .raddr (in_set),
    .rdata (w1_rdata)
  );

  // Way 0 entries hold {lru, valid, tag, line}; way 1 entries hold {valid, tag, line}.
  assign lru0 = w0_rdata[W0_W-1];
  assign v0   = w0_rdata[W0_W-2];
  assign t0   = w0_rdata[LINE_W +: TAG_W];
  assign l0   = w0_rdata[LINE_W-1:0];
  assign v1   = w1_rdata[W1_W-1];
  assign t1   = w1_rdata[LINE_W +: TAG_W];
  assign l1   = w1_rdata[LINE_W-1:0];

  assign hit0    = v0 && (t0 == cur_tag);
  assign hit1    = !hit0 && v1 && (t1 == cur_tag);
  assign hit_any = hit0 || hit1;

  always_comb begin
    if (hit0) begin
      way_sel  = tlrc_pkg::WAY_ZERO;
      line_sel = l0;
    end else if (hit1) begin
      way_sel  = tlrc_pkg::WAY_ONE;
      line_sel = l1;
    end else begin
      way_sel  = lru0;
      line_sel = fill_line;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlrc_pkg::S_CLEAR: begin
        if (clr_idx_r == SET_W'(NUM_SETS - 1)) begin
          state_nxt = tlrc_pkg::S_IDLE;
        end
      end
      tlrc_pkg::S_IDLE: begin
        if (rd_issue) begin
          state_nxt = tlrc_pkg::S_LOOK;
        end
      end
      tlrc_pkg::S_LOOK: begin
        if (slot_free) begin
          state_nxt = tlrc_pkg::S_IDLE;
        end
      end
      default: state_nxt = tlrc_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    clearing    = 1'b0;
    look_done   = 1'b0;
    case (state_r)
      tlrc_pkg::S_CLEAR: clearing    = 1'b1;
      tlrc_pkg::S_IDLE:  in_ch.ready = 1'b1;
      tlrc_pkg::S_LOOK:  look_done   = slot_free;
      default: begin
      end
    endcase
  end

  always_comb begin
    way_waddr = clearing ? clr_idx_r : cur_set;
    w0_we     = clearing || look_done;
    w1_we     = clearing || (look_done && !hit_any && (way_sel == tlrc_pkg::WAY_ONE));
    if (clearing) begin
      w0_wdata = '0;
      w1_wdata = '0;
    end else begin
      w1_wdata = {1'b1, cur_tag, fill_line};
      if (!hit_any && (way_sel == tlrc_pkg::WAY_ZERO)) begin
        w0_wdata = {~way_sel, 1'b1, cur_tag, fill_line};
      end else begin
        w0_wdata = {~way_sel, v0, t0, l0};
      end
    end
  end

  always_comb begin
    clr_idx_nxt   = clearing ? clr_idx_r + SET_W'(1) : clr_idx_r;
    addr_nxt      = rd_issue ? in_ch.address : addr_r;
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    out_hit_nxt   = out_hit_r;
    out_way_nxt   = out_way_r;
    if (look_done) begin
      if (hit_any) begin
        hit_cnt_nxt = hit_cnt_r + tlrc_pkg::CNT_W'(1);
      end else begin
        miss_cnt_nxt = miss_cnt_r + tlrc_pkg::CNT_W'(1);
      end
      out_valid_nxt = 1'b1;
      out_data_nxt  = line_sel[cur_off*DW +: DW];
      out_hit_nxt   = hit_any;
      out_way_nxt   = way_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlrc_pkg::S_CLEAR;
      clr_idx_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
    out_hit_r  <= out_hit_nxt;
    out_way_r  <= out_way_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = out_data_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.served_way = out_way_r;
  assign out_ch.hit_total  = hit_cnt_r;
  assign out_ch.miss_total = miss_cnt_r;

endmodule
